### sv/nck_pkg.sv
// Shared types and constants of the natural collation key block.
package nck_pkg;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_RAW   = 2'd1;
   localparam kind_type KIND_DIGIT = 2'd2;
   localparam kind_type KIND_OTHER = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       end_of_value;
   } req_type;

   typedef struct packed {
      logic        key_valid;
      logic [7:0]  key_byte;
      logic        done_res;
      logic [1:0]  status;
      logic        unpadded;
      logic [15:0] key_length;
   } rsp_type;

   typedef struct packed {
      logic        natural;
      logic        malformed;
      logic [4:0]  width;
      logic [15:0] cap;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] in_byte;
      logic       last;
   } cmd_type;

endpackage

### sv/nck_front.sv
// Front end: accepts input words, classifies each byte and queues a command.
module nck_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  nck_pkg::req_type req_data,
   input  nck_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             q_push,
   output nck_pkg::cmd_type q_cmd
);
   import nck_pkg::*;

   kind_type kind;
   logic     numeral;

   assign numeral = (req_data.in_byte >= CH_ZERO) && (req_data.in_byte <= CH_NINE);

   always_comb begin
      if (!req_data.has_byte || cfg.malformed) begin
         kind = KIND_NONE;
      end else if (!cfg.natural) begin
         kind = KIND_RAW;
      end else if (numeral) begin
         kind = KIND_DIGIT;
      end else begin
         kind = KIND_OTHER;
      end
   end

   assign req_stall     = q_full;
   assign q_push        = req_valid && !q_full &&
                          ((kind != KIND_NONE) || req_data.end_of_value);
   assign q_cmd.kind    = kind;
   assign q_cmd.in_byte = req_data.in_byte;
   assign q_cmd.last    = req_data.end_of_value;

endmodule

### sv/nck_queue.sv
// Two-entry command queue between the front end and the key sequencer.
module nck_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nck_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output nck_pkg::cmd_type head_cmd
);
   import nck_pkg::*;

   localparam logic [1:0] DEPTH = 2'd2;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == DEPTH);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/nck_back.sv
// Key sequencer: holds the pending digit run and emits key and closing words.
module nck_back #(
   parameter int MAX_DIGIT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  nck_pkg::cfg_type cfg,
   input  logic             cfg_write,
   input  logic             q_valid,
   input  nck_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nck_pkg::rsp_type rsp_data
);
   import nck_pkg::*;

   localparam int IDX_W = (MAX_DIGIT_WIDTH > 1) ? $clog2(MAX_DIGIT_WIDTH) : 1;

   localparam logic [2:0] P_IDLE  = 3'd0;
   localparam logic [2:0] P_PAD   = 3'd1;
   localparam logic [2:0] P_FLUSH = 3'd2;
   localparam logic [2:0] P_BYTE  = 3'd3;
   localparam logic [2:0] P_CLOSE = 3'd4;

   typedef struct packed {
      logic [7:0] key;
      logic       byte_pend;
      logic       last;
   } cur_type;

   logic [3:0]  digit_ff [MAX_DIGIT_WIDTH];
   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [4:0]  run_len_ff, run_len_in;
   logic        in_long_ff, in_long_in;
   logic        saw_long_ff, saw_long_in;
   logic [15:0] emitted_ff, emitted_in;
   logic        over_ff, over_in;
   cur_type     cur_ff, cur_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic             step_ok;
   logic             emit_req;
   logic [7:0]       emit_byte;
   logic             close_req;
   logic             dig_we;
   logic [4:0]       run_len_inc;
   logic [4:0]       cnt_inc;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic [1:0]       close_status;

   assign step_ok     = !rsp_valid_ff || !rsp_stall;
   assign run_len_inc = run_len_ff + 5'd1;
   assign cnt_inc     = cnt_ff + 5'd1;
   assign wr_idx      = IDX_W'(run_len_ff);
   assign rd_idx      = IDX_W'(cnt_ff);
   assign close_status = cfg.malformed ? ST_MALFORMED : (over_ff ? ST_RANGE : ST_OK);

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      run_len_in  = run_len_ff;
      in_long_in  = in_long_ff;
      saw_long_in = saw_long_ff;
      emitted_in  = emitted_ff;
      over_in     = over_ff;
      cur_in      = cur_ff;
      q_pop       = 1'b0;
      emit_req    = 1'b0;
      emit_byte   = cur_ff.key;
      close_req   = 1'b0;
      dig_we      = 1'b0;

      unique case (phase_ff)
         P_IDLE: begin
            if (q_valid) begin
               q_pop            = 1'b1;
               cur_in.key       = q_cmd.in_byte;
               cur_in.last      = q_cmd.last;
               cur_in.byte_pend = 1'b0;
               case (q_cmd.kind)
                  KIND_RAW: begin
                     phase_in = P_BYTE;
                  end
                  KIND_DIGIT: begin
                     if (in_long_ff) begin
                        phase_in = P_BYTE;
                     end else begin
                        dig_we     = 1'b1;
                        run_len_in = run_len_inc;
                        if (run_len_inc >= cfg.width) begin
                           in_long_in  = 1'b1;
                           saw_long_in = 1'b1;
                           cnt_in      = 5'd0;
                           phase_in    = P_FLUSH;
                        end else if (q_cmd.last) begin
                           cnt_in   = run_len_inc;
                           phase_in = P_PAD;
                        end
                     end
                  end
                  KIND_OTHER: begin
                     in_long_in = 1'b0;
                     if (run_len_ff != 5'd0) begin
                        cur_in.byte_pend = 1'b1;
                        cnt_in           = run_len_ff;
                        phase_in         = P_PAD;
                     end else begin
                        phase_in = P_BYTE;
                     end
                  end
                  default: begin
                     if (run_len_ff != 5'd0) begin
                        cnt_in   = run_len_ff;
                        phase_in = P_PAD;
                     end else begin
                        phase_in = P_CLOSE;
                     end
                  end
               endcase
            end
         end
         P_PAD: begin
            if (step_ok) begin
               emit_req  = 1'b1;
               emit_byte = CH_ZERO;
               cnt_in    = cnt_inc;
               if (cnt_inc == cfg.width) begin
                  cnt_in   = 5'd0;
                  phase_in = P_FLUSH;
               end
            end
         end
         P_FLUSH: begin
            if (step_ok) begin
               emit_req  = 1'b1;
               emit_byte = {CH_ZERO[7:4], digit_ff[rd_idx]};
               cnt_in    = cnt_inc;
               if (cnt_inc == run_len_ff) begin
                  run_len_in = 5'd0;
                  cnt_in     = 5'd0;
                  if (cur_ff.byte_pend) begin
                     phase_in = P_BYTE;
                  end else if (cur_ff.last) begin
                     phase_in = P_CLOSE;
                  end else begin
                     phase_in = P_IDLE;
                  end
               end
            end
         end
         P_BYTE: begin
            if (step_ok) begin
               emit_req  = 1'b1;
               emit_byte = cur_ff.key;
               phase_in  = cur_ff.last ? P_CLOSE : P_IDLE;
            end
         end
         P_CLOSE: begin
            if (step_ok) begin
               close_req   = 1'b1;
               run_len_in  = 5'd0;
               in_long_in  = 1'b0;
               saw_long_in = 1'b0;
               emitted_in  = 16'd0;
               over_in     = 1'b0;
               phase_in    = P_IDLE;
            end
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit_req) begin
         if (emitted_ff < cfg.cap) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in            = '0;
            rsp_data_in.key_valid  = 1'b1;
            rsp_data_in.key_byte   = emit_byte;
            emitted_in             = emitted_ff + 16'd1;
         end else begin
            over_in = 1'b1;
         end
      end
      if (close_req) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in             = '0;
         rsp_data_in.done_res    = 1'b1;
         rsp_data_in.status      = close_status;
         rsp_data_in.unpadded    = (close_status == ST_OK) && saw_long_ff;
         rsp_data_in.key_length  = (close_status == ST_OK) ? emitted_ff : 16'd0;
      end

      if (cfg_write) begin
         phase_in    = P_IDLE;
         cnt_in      = 5'd0;
         run_len_in  = 5'd0;
         in_long_in  = 1'b0;
         saw_long_in = 1'b0;
         emitted_in  = 16'd0;
         over_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_IDLE;
         cnt_ff       <= 5'd0;
         run_len_ff   <= 5'd0;
         in_long_ff   <= 1'b0;
         saw_long_ff  <= 1'b0;
         emitted_ff   <= 16'd0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         run_len_ff   <= run_len_in;
         in_long_ff   <= in_long_in;
         saw_long_ff  <= saw_long_in;
         emitted_ff   <= emitted_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      if (dig_we) begin
         digit_ff[wr_idx] <= q_cmd.in_byte[3:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_run_below_width: assert property (@(posedge clock) disable iff (reset)
      (run_len_ff != 5'd0 && phase_ff != P_FLUSH) |-> run_len_ff < cfg.width)
      else $error("Pending digit run reached the digit width without a flush.");

   a_count_within_cap: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= cfg.cap)
      else $error("Emitted key length exceeds the capacity.");

   a_long_run_seen: assert property (@(posedge clock) disable iff (reset)
      in_long_ff |-> saw_long_ff)
      else $error("Long run active without the unpadded flag set.");

   a_close_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_res && rsp_data_ff.status != ST_OK)
      |-> (rsp_data_ff.key_length == 16'd0 && !rsp_data_ff.unpadded))
      else $error("Failed closing word carries a length or an unpadded flag.");

endmodule

### sv/natural_collation_key_core.sv
// Top level of the natural collation key block: registers, front end, queue and sequencer.
//
// A value enters as a stream of request words, one byte each, with has_byte marking a
// data byte and end_of_value marking the last word of the value. The block answers
// with response words: one key byte each, then one closing word that carries the
// status, the unpadded flag and the key length.
// In raw mode each byte leaves as a key byte. In natural mode digit runs are held
// in a run buffer and leave when the run ends, left-padded with '0' to the digit width;
// a run that reaches the width leaves unpadded, and its later digits pass through.
// The sequencer decodes an accepted word in its idle state, then emits its key bytes and
// closing word one per cycle, waiting while rsp_stall holds a valid response word, and
// takes no new word until done. A two-entry queue lets the request side run ahead of it.
// The user is to write the control registers through the csr port only while no value is
// in flight; the block does not enforce this. A mode, width or cap write abandons the
// current value. Reset sets natural mode, a digit width of 8 and a capacity of 65535,
// and empties the queue and the output register.
module natural_collation_key_core #(
   parameter int MAX_DIGIT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nck_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nck_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [nck_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nck_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import nck_pkg::*;

   logic        mode_ff, mode_in;
   logic [4:0]  width_ff, width_in;
   logic [15:0] cap_ff, cap_in;
   logic [4:0]  eff_width;
   cfg_type     cfg;
   logic        cfg_write;

   logic        q_full;
   logic        q_push;
   cmd_type     q_push_cmd;
   logic        q_pop;
   logic        q_valid;
   cmd_type     q_head;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      cap_in    = cap_ff;
      cfg_write = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_in   = csr_wdata[0];
               cfg_write = 1'b1;
            end
            CSR_WIDTH: begin
               width_in  = csr_wdata[4:0];
               cfg_write = 1'b1;
            end
            CSR_CAP: begin
               cap_in    = csr_wdata;
               cfg_write = 1'b1;
            end
            default: begin
               cfg_write = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         width_ff <= 5'd8;
         cap_ff   <= 16'hFFFF;
      end else begin
         mode_ff  <= mode_in;
         width_ff <= width_in;
         cap_ff   <= cap_in;
      end
   end

   assign eff_width = (32'(width_ff) > MAX_DIGIT_WIDTH) ? 5'(MAX_DIGIT_WIDTH) : width_ff;

   assign cfg.natural   = mode_ff;
   assign cfg.malformed = mode_ff && (width_ff == 5'd0);
   assign cfg.width     = eff_width;
   assign cfg.cap       = cap_ff;

   nck_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_push_cmd)
   );

   nck_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   nck_back #(
      .MAX_DIGIT_WIDTH (MAX_DIGIT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_write (cfg_write),
      .q_valid   (q_valid),
      .q_cmd     (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### dv/nck_key_checker.sv
// Checker for the natural collation key block: predicts every response word and compares it.
module nck_key_checker #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  nck_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  nck_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [nck_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nck_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            end_of_test,
   output int                              fail_count,
   output int                              pending_keys
);
   import nck_pkg::*;

   logic        cfg_mode;
   logic [4:0]  cfg_width;
   logic [15:0] cfg_cap;

   logic [3:0]  run_digits [MAX_DIGITS];
   int          run_length;
   logic        in_long_run;
   logic        overflowed;
   logic        saw_long_run;
   int          emitted_count;

   rsp_type     expected_keys [$];
   int          reported;
   bit          leftovers_counted;

   function automatic rsp_type key_word(input logic valid, input logic [7:0] b,
                                        input logic done, input logic [1:0] st,
                                        input logic unp, input logic [15:0] len);
      rsp_type r;
      r.key_valid  = valid;
      r.key_byte   = b;
      r.done_res   = done;
      r.status     = st;
      r.unpadded   = unp;
      r.key_length = len;
      return r;
   endfunction

   task automatic clear_value_state();
      foreach (run_digits[i]) run_digits[i] = '0;
      run_length = 0;
      in_long_run = 1'b0;
      overflowed = 1'b0;
      saw_long_run = 1'b0;
      emitted_count = 0;
   endtask

   task automatic emit_key_byte(input logic [7:0] b);
      if (emitted_count < cfg_cap) begin
         expected_keys.push_back(key_word(1'b1, b, 1'b0, ST_OK, 1'b0, 16'd0));
         emitted_count++;
      end else begin
         overflowed = 1'b1;
      end
   endtask

   task automatic flush_digit_run(input int w, input bit pad);
      int k;
      if (pad) begin
         for (k = run_length; k < w; k++) emit_key_byte(CH_ZERO);
      end
      for (k = 0; k < run_length && k < MAX_DIGITS; k++) begin
         emit_key_byte(CH_ZERO + 8'(run_digits[k]));
      end
      run_length = 0;
   endtask

   // Works out the response words that one accepted request word causes.
   task automatic collate_word(input req_type w);
      int         w_eff;
      logic       malformed;
      logic [7:0] c;
      logic [1:0] st;
      w_eff = (cfg_width > MAX_DIGITS) ? MAX_DIGITS : int'(cfg_width);
      malformed = cfg_mode && (w_eff == 0);
      c = w.in_byte;
      if (w.has_byte && !malformed) begin
         if (!cfg_mode) begin
            emit_key_byte(c);
         end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (in_long_run) begin
               emit_key_byte(c);
            end else begin
               if (run_length < MAX_DIGITS) run_digits[run_length] = 4'(c - CH_ZERO);
               run_length++;
               if (run_length >= w_eff) begin
                  flush_digit_run(w_eff, 1'b0);
                  in_long_run = 1'b1;
                  saw_long_run = 1'b1;
               end
            end
         end else begin
            if (run_length > 0) flush_digit_run(w_eff, 1'b1);
            in_long_run = 1'b0;
            emit_key_byte(c);
         end
      end
      if (w.end_of_value) begin
         if (cfg_mode && !malformed && run_length > 0) flush_digit_run(w_eff, 1'b1);
         st = malformed ? ST_MALFORMED : (overflowed ? ST_RANGE : ST_OK);
         expected_keys.push_back(key_word(1'b0, 8'd0, 1'b1, st,
                                          (st == ST_OK) && saw_long_run,
                                          (st == ST_OK) ? 16'(emitted_count) : 16'd0));
         clear_value_state();
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         cfg_mode = 1'b1;
         cfg_width = 5'd8;
         cfg_cap = 16'hFFFF;
         clear_value_state();
         expected_keys.delete();
         fail_count = 0;
         reported = 0;
         leftovers_counted = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_keys.size() == 0) begin
               fail_count++;
               if (reported < 10) begin
                  $display("Unexpected response word: valid=%0d byte=%h done=%0d status=%0d",
                           rsp_data.key_valid, rsp_data.key_byte, rsp_data.done_res,
                           rsp_data.status);
                  reported++;
               end
            end else begin
               exp_word = expected_keys.pop_front();
               if (rsp_data.key_valid !== exp_word.key_valid ||
                   rsp_data.key_byte !== exp_word.key_byte ||
                   rsp_data.done_res !== exp_word.done_res ||
                   rsp_data.status !== exp_word.status ||
                   rsp_data.unpadded !== exp_word.unpadded ||
                   rsp_data.key_length !== exp_word.key_length) begin
                  fail_count++;
                  if (reported < 10) begin
                     $display("Mismatch: expected valid=%0d byte=%h done=%0d status=%0d",
                              exp_word.key_valid, exp_word.key_byte, exp_word.done_res,
                              exp_word.status, " unpadded=%0d length=%0d",
                              exp_word.unpadded, exp_word.key_length);
                     $display("          actual   valid=%0d byte=%h done=%0d status=%0d",
                              rsp_data.key_valid, rsp_data.key_byte, rsp_data.done_res,
                              rsp_data.status, " unpadded=%0d length=%0d",
                              rsp_data.unpadded, rsp_data.key_length);
                     reported++;
                  end
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE: begin
                  cfg_mode = csr_wdata[0];
                  clear_value_state();
               end
               CSR_WIDTH: begin
                  cfg_width = csr_wdata[4:0];
                  clear_value_state();
               end
               CSR_CAP: begin
                  cfg_cap = csr_wdata[15:0];
                  clear_value_state();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) collate_word(req_data);
         if (end_of_test && !leftovers_counted) begin
            leftovers_counted = 1'b1;
            if (expected_keys.size() != 0) begin
               fail_count += expected_keys.size();
               $display("%0d expected response words never arrived", expected_keys.size());
            end
         end
      end
      pending_keys = expected_keys.size();
   end

endmodule

### dv/tb_natural_collation_key_core.sv
// Testbench top of the natural collation key block: stimulus, flow control and verdict.
module tb_natural_collation_key_core;
   import nck_pkg::*;

   localparam int ITEM_TARGET      = 460;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   end_of_test;

   int fail_count;
   int pending_keys;
   int items_sent = 0;
   int gap_max = 0;
   int burst_left = 1;
   int cycle_count = 0;
   bit long_hold_pending = 1'b0;

   natural_collation_key_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   nck_key_checker key_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .end_of_test  (end_of_test),
      .fail_count   (fail_count),
      .pending_keys (pending_keys)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The receiver changes its stall pattern now and then, and on request holds off for a
   // long stretch so that the block backs up into its request side.
   initial begin
      stall_style_type style;
      int              style_left;
      int              hold_left;
      style = STALL_NONE;
      style_left = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            if (style_left == 0) begin
               style = stall_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(20, 80);
            end
            style_left--;
            case (style)
               STALL_NONE:  rsp_stall = 1'b0;
               STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall = ($urandom_range(0, 9) < 6);
               default:     rsp_stall = (style_left % 3 == 0);
            endcase
         end
      end
   end

   task automatic send_word(input logic [7:0] b, input logic has, input logic eov);
      req_data.in_byte = b;
      req_data.has_byte = has;
      req_data.end_of_value = eov;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (has || eov) items_sent++;
      if (gap_max > 0) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, close && (i == s.len() - 1));
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_keys != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_register(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Mostly well-formed values built from digit runs and other bytes, with some noise.
   task automatic send_random_value(input int run_max);
      int         kind;
      logic [7:0] c;
      repeat ($urandom_range(1, 5)) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            repeat ($urandom_range(1, run_max)) begin
               send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1, 1'b0);
            end
         end else if (kind < 9) begin
            repeat ($urandom_range(1, 3)) begin
               c = 8'($urandom_range(0, 255));
               if (c >= CH_ZERO && c <= CH_NINE) c = c ^ 8'h40;
               send_word(c, 1'b1, 1'b0);
            end
         end else begin
            send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
      send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
   endtask

   initial begin
      logic                  mode_bit;
      logic [4:0]            width;
      logic [15:0]           cap;
      logic [CSR_DATA_W-1:0] wdata;
      int                    run_max;
      int                    phase_no;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_MODE;
      csr_wdata = '0;
      end_of_test = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Settings after reset: natural mode, digit width 8, full capacity.
      send_word(8'h00, 1'b1, 1'b0);
      send_text("19", 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(CH_NINE, 1'b1, 1'b1);
      send_word(8'hA5, 1'b0, 1'b0);
      send_word(8'h5A, 1'b0, 1'b1);

      program_register(CSR_WIDTH, 16'hFFE3);
      send_text("/1234:5", 1'b1);

      program_register(CSR_MODE, 16'hFFFE);
      send_text("42", 1'b1);

      program_register(CSR_MODE, 16'h0001);
      program_register(CSR_WIDTH, 16'h0000);
      send_text("a", 1'b1);

      program_register(CSR_WIDTH, 16'h001F);
      send_text("5", 1'b1);

      program_register(CSR_WIDTH, 16'd8);
      program_register(CSR_CAP, 16'd2);
      send_text("abc", 1'b1);

      program_register(CSR_CAP, 16'd0);
      send_word(8'h7A, 1'b1, 1'b1);
      program_register(CSR_UNUSED, 16'd5);
      send_word(8'h71, 1'b1, 1'b1);

      // A value cut short by a register write is abandoned.
      program_register(CSR_CAP, 16'hFFFF);
      send_text("12", 1'b0);
      program_register(CSR_WIDTH, 16'd4);
      send_text("7:", 1'b1);

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         mode_bit = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       width = 5'd0;
            1:       width = 5'($urandom_range(17, 31));
            default: width = 5'($urandom_range(1, 16));
         endcase
         cap = ($urandom_range(0, 9) < 7) ? 16'hFFFF : 16'($urandom_range(0, 40));
         if (phase_no == 1) begin
            mode_bit = 1'b1;
            if (width == 5'd0) width = 5'd6;
            cap = 16'hFFFF;
         end
         wdata = 16'($urandom);
         wdata[0] = mode_bit;
         program_register(CSR_MODE, wdata);
         wdata = 16'($urandom);
         wdata[4:0] = width;
         program_register(CSR_WIDTH, wdata);
         program_register(CSR_CAP, cap);
         if ($urandom_range(0, 7) == 0) program_register(CSR_UNUSED, 16'($urandom));

         if (!mode_bit) run_max = 6;
         else if (width == 5'd0) run_max = 3;
         else if (width > 5'd16) run_max = 18;
         else run_max = int'(width) + 2;

         gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (phase_no == 1) begin
            gap_max = 0;
            long_hold_pending = 1'b1;
         end
         repeat ($urandom_range(2, 4)) send_random_value(run_max);
         if (phase_no % 4 == 3) wait_drained();
         phase_no++;
      end

      wait_drained();
      end_of_test = 1'b1;
      @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
sv/nck_pkg.sv
sv/nck_front.sv
sv/nck_queue.sv
sv/nck_back.sv
sv/natural_collation_key_core.sv
dv/nck_key_checker.sv
dv/tb_natural_collation_key_core.sv
